[hw/rtl/pcm_rms_db_volume_meter_top_macros.svh]
// Assertion macros for the RMS dB volume meter.
// Used by the top level; expects clk_i and rst_ni in the including scope.
`ifndef PCM_RMS_DB_VOLUME_METER_TOP_MACROS_SVH
`define PCM_RMS_DB_VOLUME_METER_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RMSDB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define RMSDB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/rmsdb_pkg.sv]
// Package of the RMS dB volume meter: payload types, divider control types,
// fixed constants and the sample magnitude function. No dependencies.
`default_nettype none

package rmsdb_pkg;

  typedef struct packed {
    logic [15:0] sample;
    logic        last_in_block;
  } smp_t;

  typedef struct packed {
    logic [14:0] volume_q8;
  } vol_t;

  typedef struct packed {
    logic sample_mode;
  } cfg_t;

  typedef struct packed {
    logic start;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Mode codes of the sample_mode register.
  localparam logic MODE_SIGNED   = 1'b0;
  localparam logic MODE_UNSIGNED = 1'b1;

  // Mean square of the sample magnitudes, times 2^16, never exceeds 2^46.
  localparam int unsigned Q_W   = 47;
  localparam int unsigned E_W   = 6;
  localparam logic [E_W-1:0] Q_TOP = 6'd46;

  localparam logic [14:0] FULL_Q8  = 15'd25600;
  localparam logic [26:0] LOGK     = 27'd84174088;
  localparam logic [21:0] LOG_BIAS = 22'd3014656;

  function automatic logic [15:0] magnitude(input logic [15:0] s, input logic mode);
    logic [15:0] m;
    if (mode == MODE_SIGNED) begin
      m = s[15] ? (~s + 16'd1) : s;
    end else begin
      m = s[15] ? {1'b0, s[14:0]} : (16'h8000 - s);
    end
    return m;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/rmsdb_chan_if.sv]
// Valid/ready channel interface carrying one packed payload item.
// Payload types come from rmsdb_pkg at instantiation.
`default_nettype none

interface rmsdb_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[hw/rtl/rmsdb_div.sv]
// Restoring divider, one quotient bit per cycle.
// Uses the control and status structs of rmsdb_pkg.
`default_nettype none

module rmsdb_div #(
  parameter int unsigned NUM_W = 59,
  parameter int unsigned DEN_W = 13
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire rmsdb_pkg::div_ctrl_t ctrl_i,
  input  wire logic [NUM_W-1:0]     num_i,
  input  wire logic [DEN_W-1:0]     den_i,
  output rmsdb_pkg::div_stat_t      stat_o,
  output logic [NUM_W-1:0]          quo_o
);

  localparam int unsigned CNT_W = $clog2(NUM_W);

  logic [NUM_W-1:0] num_q;
  logic [DEN_W-1:0] rem_q;
  logic [DEN_W-1:0] den_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             done_q;
  logic [DEN_W:0]   trial;
  logic             fits;

  // The numerator shifts out at the top while quotient bits shift in below.
  assign trial = {rem_q, num_q[NUM_W-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q  <= '0;
      rem_q  <= '0;
      den_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (ctrl_i.start) begin
        num_q  <= num_i;
        den_q  <= den_i;
        rem_q  <= '0;
        cnt_q  <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        rem_q <= fits ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
        num_q <= {num_q[NUM_W-2:0], fits};
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(NUM_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quo_o       = num_q;

endmodule

`default_nettype wire

[hw/rtl/rmsdb_mul.sv]
// Shared 32 x 32 unsigned multiplier with a registered product.
// No package dependencies.
`default_nettype none

module rmsdb_mul (
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  wire logic [31:0] a_i,
  input  wire logic [31:0] b_i,
  output logic [63:0]      prod_o
);

  logic [63:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= 64'(a_i) * 64'(b_i);
    end
  end

  assign prod_o = prod_q;

endmodule

`default_nettype wire

[hw/rtl/pcm_rms_db_volume_meter_top.sv]
// Top level of the RMS dB volume meter: sequencer, accumulators and result register.
// Depends on rmsdb_pkg, rmsdb_chan_if, rmsdb_div, rmsdb_mul and the macros header.
//
//   channel  direction  payload                          accepted when
//   smp_i    in         sample[15:0], last_in_block      valid && ready
//   cfg_i    in         sample_mode                      valid && ready (always ready)
//   vol_o    out        volume_q8[14:0]                  valid && ready
//
// A sample that does not close a block is accepted in ST_IDLE, then accumulated in ST_ACC.
// A closing sample then goes through the divider (one quotient bit per cycle), the
// normalizing shift, the log2 squaring loop and the final dB scaling before it is emitted.
// The shared multiplier squares samples, runs 16 squarings of the log2 mantissa and
// forms the final dB scaling; each product is registered and then consumed by the sequencer.
// Reset clears the accumulators, the mode and all control; no clearing pass is needed.
// A finished volume waits in its output register while the next sample is taken;
// only a second result stalls, until the first one has been taken.
`default_nettype none
`include "pcm_rms_db_volume_meter_top_macros.svh"

module pcm_rms_db_volume_meter_top #(
  parameter int unsigned MAX_BLOCK = 4096
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  rmsdb_chan_if.sink  smp_i,
  rmsdb_chan_if.sink  cfg_i,
  rmsdb_chan_if.source vol_o
);

  localparam int unsigned TALLY_W = $clog2(MAX_BLOCK + 1);
  localparam int unsigned SUM_W   = 31 + $clog2(MAX_BLOCK);
  localparam int unsigned NUM_W   = SUM_W + 16;
  localparam int unsigned QW      = rmsdb_pkg::Q_W;
  localparam int unsigned EW      = rmsdb_pkg::E_W;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ACC,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_NORM,
    ST_SQ_MUL,
    ST_SQ_UPD,
    ST_FIN_MUL,
    ST_FIN_CALC,
    ST_EMIT
  } state_e;

  state_e               state_q;
  logic                 mode_q;
  logic [SUM_W-1:0]     sum_q;
  logic [TALLY_W-1:0]   tally_q;
  logic                 acc_q;
  logic                 last_q;
  logic [QW-1:0]        q_q;
  logic [EW-1:0]        e_q;
  logic [31:0]          x_q;
  logic [15:0]          frac_q;
  logic [3:0]           iter_q;
  logic [14:0]          res_q;
  logic                 vol_valid_q;
  logic [14:0]          vol_data_q;

  logic                 smp_fire;
  logic                 room;
  logic                 mul_en;
  logic [31:0]          mul_a;
  logic [31:0]          mul_b;
  logic [63:0]          prod;
  logic [15:0]          mag;
  logic [21:0]          neg_log;
  logic [32:0]          sq_val;
  logic [16:0]          db_ceil;
  rmsdb_pkg::div_ctrl_t div_ctrl;
  rmsdb_pkg::div_stat_t div_stat;
  logic [NUM_W-1:0]     quo;

  assign smp_i.ready = (state_q == ST_IDLE);
  assign smp_fire    = smp_i.valid && smp_i.ready;
  assign cfg_i.ready = 1'b1;
  assign room        = tally_q < TALLY_W'(MAX_BLOCK);

  assign mag     = rmsdb_pkg::magnitude(smp_i.data.sample, mode_q);
  // Distance of log2(Q) below full scale in Q16; never negative since Q <= 2^46.
  assign neg_log = rmsdb_pkg::LOG_BIAS - {e_q, frac_q};
  // One squaring step of the log2 mantissa: (x * x) >> 31.
  assign sq_val  = prod[63:31];
  // Ceiling of LOGK * neg_log / 2^32; the product stays below 2^48.
  assign db_ceil = 17'(prod[48:32]) + 17'(|prod[31:0]);

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_en = 1'b0;
    mul_a  = '0;
    mul_b  = '0;
    unique case (state_q)
      ST_IDLE: begin
        mul_en = smp_fire;
        mul_a  = 32'(mag);
        mul_b  = 32'(mag);
      end
      ST_SQ_MUL: begin
        mul_en = 1'b1;
        mul_a  = x_q;
        mul_b  = x_q;
      end
      ST_FIN_MUL: begin
        mul_en = 1'b1;
        mul_a  = 32'(rmsdb_pkg::LOGK);
        mul_b  = 32'(neg_log);
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  assign div_ctrl.start = (state_q == ST_DIV_GO);

  rmsdb_mul u_mul (
    .clk_i  (clk_i),
    .en_i   (mul_en),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  rmsdb_div #(
    .NUM_W (NUM_W),
    .DEN_W (TALLY_W)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (div_ctrl),
    .num_i  ({sum_q, 16'd0}),
    .den_i  (tally_q),
    .stat_o (div_stat),
    .quo_o  (quo)
  );

  // Sequencer, accumulators and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mode_q      <= rmsdb_pkg::MODE_SIGNED;
      sum_q       <= '0;
      tally_q     <= '0;
      acc_q       <= 1'b0;
      last_q      <= 1'b0;
      q_q         <= '0;
      e_q         <= '0;
      x_q         <= '0;
      frac_q      <= '0;
      iter_q      <= '0;
      res_q       <= '0;
      vol_valid_q <= 1'b0;
      vol_data_q  <= '0;
    end else begin
      if (cfg_i.valid) begin
        mode_q <= cfg_i.data.sample_mode;
      end
      if (vol_o.ready) begin
        vol_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (smp_fire) begin
            acc_q   <= room;
            last_q  <= smp_i.data.last_in_block;
            state_q <= ST_ACC;
          end
        end
        ST_ACC: begin
          if (acc_q) begin
            sum_q   <= sum_q + SUM_W'(prod[30:0]);
            tally_q <= tally_q + TALLY_W'(1);
          end
          state_q <= last_q ? ST_DIV_GO : ST_IDLE;
        end
        ST_DIV_GO: begin
          // The divider latches sum and count at this edge.
          sum_q   <= '0;
          tally_q <= '0;
          state_q <= ST_DIV_WAIT;
        end
        ST_DIV_WAIT: begin
          if (div_stat.done) begin
            if (quo[QW-1:0] == '0) begin
              res_q   <= '0;
              state_q <= ST_EMIT;
            end else begin
              q_q     <= quo[QW-1:0];
              e_q     <= rmsdb_pkg::Q_TOP;
              state_q <= ST_NORM;
            end
          end
        end
        ST_NORM: begin
          if (q_q[QW-1]) begin
            x_q     <= q_q[QW-1:QW-32];
            frac_q  <= '0;
            iter_q  <= '0;
            state_q <= ST_SQ_MUL;
          end else begin
            q_q <= {q_q[QW-2:0], 1'b0};
            e_q <= e_q - EW'(1);
          end
        end
        ST_SQ_MUL: begin
          state_q <= ST_SQ_UPD;
        end
        ST_SQ_UPD: begin
          frac_q <= {frac_q[14:0], sq_val[32]};
          x_q    <= sq_val[32] ? sq_val[32:1] : sq_val[31:0];
          iter_q <= iter_q + 4'd1;
          state_q <= (iter_q == 4'd15) ? ST_FIN_MUL : ST_SQ_MUL;
        end
        ST_FIN_MUL: begin
          state_q <= ST_FIN_CALC;
        end
        ST_FIN_CALC: begin
          res_q   <= (db_ceil >= 17'(rmsdb_pkg::FULL_Q8)) ? 15'd0
                   : 15'(17'(rmsdb_pkg::FULL_Q8) - db_ceil);
          state_q <= ST_EMIT;
        end
        ST_EMIT: begin
          if (!vol_valid_q || vol_o.ready) begin
            vol_valid_q <= 1'b1;
            vol_data_q  <= res_q;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign vol_o.valid          = vol_valid_q;
  assign vol_o.data.volume_q8 = vol_data_q;

  `RMSDB_ASSERT_NOW(a_vol_range, vol_o.valid, vol_o.data.volume_q8 <= rmsdb_pkg::FULL_Q8, "volume above full scale")
  `RMSDB_ASSERT_NOW(a_tally_cap, 1'b1, tally_q <= TALLY_W'(MAX_BLOCK), "sample count beyond block limit")
  `RMSDB_ASSERT_NOW(a_div_idle, smp_i.ready, !div_stat.busy, "sample taken while divider busy")
  `RMSDB_ASSERT_NEXT(a_accept_blocks, smp_fire, !smp_i.ready, "ready held right after a sample")

endmodule

`default_nettype wire

[bench/tb.sv]
`timescale 1ns / 100ps
// Self-checking bench for the RMS dB volume meter: drives PCM samples and mode writes
// through the valid/ready channels and predicts every volume reading bit for bit.
// Depends on rmsdb_pkg, rmsdb_chan_if and pcm_rms_db_volume_meter_top.

module tb;

  localparam int unsigned BLOCK_LIMIT = 4096;
  // Cycles to let pass once every expected volume has arrived: covers a closing
  // sample with a wide margin.
  localparam int unsigned SETTLE_CYCLES = 300;

  // Predicts the volume readings. It keeps its own copy of the mode register and
  // of both accumulators, and queues the volumes that are due in order.
  class meter_scoreboard;
    logic            mode;
    longint unsigned energy;
    int unsigned     count;
    logic [14:0]     volumes_due[$];
    int              errors;

    function new();
      mode = rmsdb_pkg::MODE_SIGNED;
      energy = 0;
      count = 0;
      errors = 0;
    endfunction

    // Volume in Q8 from a sum of squares over n samples, via a 16-bit log2.
    function logic [14:0] volume_of(longint unsigned sum, int unsigned n);
      longint unsigned q;
      longint unsigned x;
      int              e;
      int              i;
      int unsigned     frac;
      longint          t;
      longint          p;
      longint          v;
      if (n == 0 || sum == 0) return 15'd0;
      q = (sum << 16) / n;
      if (q == 0) return 15'd0;
      e = 63;
      while (((q >> e) & 64'd1) == 64'd0) e--;
      if (e <= 31) x = q << (31 - e);
      else x = q >> (e - 31);
      frac = 0;
      for (i = 0; i < 16; i++) begin
        x = (x * x) >> 31;
        frac = frac << 1;
        if (x >= 64'h1_0000_0000) begin
          frac = frac | 1;
          x = x >> 1;
        end
      end
      t = longint'(e) * 65536 + longint'(frac) - 46 * 65536;
      p = 64'sd84174088 * t;
      v = 25600 + (p >>> 32);
      if (v < 0) v = 0;
      if (v > 25600) v = 25600;
      return v[14:0];
    endfunction

    function void take_sample(logic [15:0] s, logic last);
      longint unsigned m;
      if (count < BLOCK_LIMIT) begin
        if (mode == rmsdb_pkg::MODE_SIGNED) m = s[15] ? (64'h10000 - s) : s;
        else m = s[15] ? (s - 64'h8000) : (64'h8000 - s);
        energy += m * m;
        count++;
      end
      if (last) begin
        volumes_due.push_back(volume_of(energy, count));
        energy = 0;
        count = 0;
      end
    endfunction

    function void check_volume(logic [14:0] got);
      logic [14:0] want;
      if (volumes_due.size() == 0) begin
        $display("%0t: unexpected volume, expected none, got %0d", $time, got);
        errors++;
      end else begin
        want = volumes_due.pop_front();
        if (got !== want) begin
          $display("%0t: volume_q8 mismatch, expected %0d, got %0d", $time, want, got);
          errors++;
        end
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  // While calm is set neither the sample sender nor the volume receiver idles.
  logic calm;

  meter_scoreboard board;

  rmsdb_chan_if #(.payload_t(rmsdb_pkg::smp_t)) smp_if ();
  rmsdb_chan_if #(.payload_t(rmsdb_pkg::cfg_t)) cfg_if ();
  rmsdb_chan_if #(.payload_t(rmsdb_pkg::vol_t)) vol_if ();

  pcm_rms_db_volume_meter_top #(
    .MAX_BLOCK(BLOCK_LIMIT)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .smp_i (smp_if),
    .cfg_i (cfg_if),
    .vol_o (vol_if)
  );

  always #5 clk_i = ~clk_i;

  // The volume receiver stalls at random, with a probability of 31 percent, unless calm is set.
  always @(posedge clk_i) begin
    vol_if.ready <= calm || ($urandom_range(0, 99) >= 31);
  end

  // Handshake signals are stable at the falling edge, so a volume seen there with
  // valid and ready both high is the one taken at the next rising edge.
  always @(negedge clk_i) begin
    if (rst_ni && vol_if.valid && vol_if.ready) begin
      board.check_volume(vol_if.data.volume_q8);
    end
  end

  // Sends one sample item. Random idle cycles come first; valid then stays high
  // until ready is seen, and the item is handed to the scoreboard once taken.
  // The task returns at the rising edge of acceptance and leaves valid high, so
  // the next item never lowers and raises valid within one time step.
  task automatic push_sample(input logic [15:0] s, input logic last);
    logic got;
    while (!calm && $urandom_range(0, 99) < 31) begin
      smp_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    smp_if.valid <= 1'b1;
    smp_if.data  <= '{sample: s, last_in_block: last};
    do begin
      @(negedge clk_i);
      got = smp_if.ready;
      @(posedge clk_i);
    end while (!got);
    board.take_sample(s, last);
  endtask

  // Writes the mode register once the meter is idle: all volumes delivered and
  // enough cycles passed for the last non-closing sample to be accumulated.
  task automatic write_mode(input logic m);
    logic got;
    smp_if.valid <= 1'b0;
    while (board.volumes_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= '{sample_mode: m};
    do begin
      @(negedge clk_i);
      got = cfg_if.ready;
      @(posedge clk_i);
    end while (!got);
    cfg_if.valid <= 1'b0;
    board.mode = m;
  endtask

  // Turns a signed value into the raw sample bits of the current mode. In
  // unsigned mode the offset of 32768 is a flip of the top bit.
  function automatic logic [15:0] encode(input logic [15:0] v);
    return (board.mode == rmsdb_pkg::MODE_SIGNED) ? v : (v ^ 16'h8000);
  endfunction

  // Random blocks of random content. Most blocks are short so that volumes are
  // frequent; about one in twenty is long. Sample levels span from silence up to
  // full scale so that the readout covers both clamps and the range between.
  task automatic random_phase(input int items);
    int          i;
    int          left;
    logic [15:0] mag;
    logic [15:0] s;
    left = 0;
    for (i = 0; i < items; i++) begin
      if (left == 0) begin
        left = ($urandom_range(0, 19) == 0) ? $urandom_range(17, 300) : $urandom_range(1, 16);
      end
      left--;
      case ($urandom_range(0, 3))
        0: s = 16'($urandom);
        1: begin
          mag = 16'($urandom_range(0, 32768) >> $urandom_range(0, 15));
          s = encode($urandom_range(0, 1) ? (~mag + 16'd1) : mag);
        end
        2: s = encode(16'd0);
        default: begin
          mag = 16'(32768 - $urandom_range(0, 255));
          s = encode($urandom_range(0, 1) ? (~mag + 16'd1) : mag);
        end
      endcase
      push_sample(s, left == 0);
    end
  endtask

  initial begin
    int i;
    board = new();
    clk_i = 1'b0;
    rst_ni = 1'b0;
    calm = 1'b0;
    smp_if.valid = 1'b0;
    smp_if.data = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    vol_if.ready = 1'b0;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Both mode values are written while the meter is fresh out of reset.
    write_mode(rmsdb_pkg::MODE_UNSIGNED);
    write_mode(rmsdb_pkg::MODE_SIGNED);

    // Signed samples: largest positive, full-scale negative, silence (zero sum),
    // the smallest non-zero levels, which fall below the zero-volume clamp, a
    // mid-range level, a silent block of several samples and one mixed block.
    push_sample(16'h7FFF, 1'b1);
    push_sample(16'h8000, 1'b1);
    push_sample(16'h0000, 1'b1);
    push_sample(16'h0001, 1'b1);
    push_sample(16'hFFFF, 1'b1);
    push_sample(16'h0100, 1'b1);
    push_sample(16'h0000, 1'b0);
    push_sample(16'h0000, 1'b0);
    push_sample(16'h0000, 1'b1);
    push_sample(16'h1234, 1'b0);
    push_sample(16'hEDCB, 1'b0);
    push_sample(16'h5555, 1'b0);
    push_sample(16'hAAAA, 1'b1);

    // Unsigned samples: the raw extremes are at or next to full scale, mid code is silence.
    write_mode(rmsdb_pkg::MODE_UNSIGNED);
    push_sample(16'h0000, 1'b1);
    push_sample(16'hFFFF, 1'b1);
    push_sample(16'h8000, 1'b1);
    push_sample(16'h8001, 1'b1);
    push_sample(16'h7FFF, 1'b1);
    push_sample(16'h8100, 1'b1);
    push_sample(16'h4000, 1'b0);
    push_sample(16'hC000, 1'b0);
    push_sample(16'h8000, 1'b1);

    // Long blocks: one of full-scale samples, and one of quiet samples that a
    // single loud sample closes.
    write_mode(rmsdb_pkg::MODE_SIGNED);
    for (i = 0; i < 40; i++) begin
      push_sample(16'h8000, i == 39);
    end
    for (i = 0; i < 40; i++) begin
      push_sample((i < 39) ? 16'h0010 : 16'h8000, i == 39);
    end

    // Random phases, with the mode set anew each time, unsigned for the first. An unclosed
    // block may carry across a mode write. The third phase runs with no idling at all.
    for (i = 0; i < 6; i++) begin
      write_mode((i == 0) ? rmsdb_pkg::MODE_UNSIGNED : logic'($urandom_range(0, 1)));
      calm = (i == 2);
      random_phase(150);
    end
    calm = 1'b0;

    smp_if.valid <= 1'b0;
    while (board.volumes_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // A run that hangs on a handshake ends here.
  initial begin
    #100ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
